>>> src/dad_pkg.sv
// Package for the date adder: widths, status codes, the queued job word
// and the calendar helper functions. No dependencies.
package dad_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int YEAR_W = 14;
    localparam int MONTH_W = 4;
    localparam int SDAY_W = 6;
    localparam int DAY_W = 5;
    localparam int OFFSET_W = 16;
    localparam int CENT_W = 8;
    localparam int MOD100_W = 7;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [MOD100_W-1:0] MOD100_LAST = 7'd99;

    // Reciprocal of 100: (y * DIV100_MUL) >> DIV100_SHIFT is exact for 14-bit years.
    localparam int DIV100_MUL = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W = YEAR_W + 13;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [YEAR_W-1:0]      year;
        logic [MONTH_W-1:0]     month;
        logic [DAY_W-1:0]       day;
        logic [OFFSET_BITS-1:0] rem;
        logic [MOD100_W-1:0]    yr_mod100;
        logic [1:0]             cent_mod4;
    } job_t;

    function automatic logic is_leap(logic [MOD100_W-1:0] yr_mod100, logic [1:0] cent_mod4);
        return (yr_mod100[1:0] == 2'b00) && ((yr_mod100 != '0) || (cent_mod4 == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] month, logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

>>> src/dad_front.sv
// Front end of the date adder: takes input words, validates the start date
// and prepares the leap-year counters. Depends on dad_pkg.
module dad_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [13:0]                start_year,
    input  logic [3:0]                 start_month,
    input  logic [5:0]                 start_day,
    input  logic [15:0]                day_offset,
    output logic                       job_push,
    output dad_pkg::job_t              job,
    input  logic                       job_full
);
    import dad_pkg::*;

    logic                   s1_valid_reg;
    logic [YEAR_W-1:0]      s1_year_reg;
    logic [MONTH_W-1:0]     s1_month_reg;
    logic [SDAY_W-1:0]      s1_day_reg;
    logic [OFFSET_BITS-1:0] s1_off_reg;
    logic [CENT_W-1:0]      s1_cent_reg;
    logic                   s2_valid_reg;
    job_t                   s2_job_reg;

    logic [PROD_W-1:0]      prod;
    logic [YEAR_W:0]        cent_x100;
    logic [MOD100_W-1:0]    yr_mod100;
    logic                   leap;
    logic [DAY_W-1:0]       len;
    logic                   bad;
    logic                   s2_free;
    logic                   s1_free;
    logic                   accept;
    logic                   s1_move;
    job_t                   job_next;

    assign prod = PROD_W'(start_year) * PROD_W'(DIV100_MUL);

    assign s2_free = !s2_valid_reg || !job_full;
    assign s1_free = !s1_valid_reg || s2_free;
    assign s1_move = s1_valid_reg && s2_free;
    assign full    = !s1_free;
    assign accept  = push && s1_free;

    always_comb
    begin
        cent_x100 = ((YEAR_W + 1)'(s1_cent_reg) << 6) + ((YEAR_W + 1)'(s1_cent_reg) << 5)
                  + ((YEAR_W + 1)'(s1_cent_reg) << 2);
        yr_mod100 = MOD100_W'((YEAR_W + 1)'(s1_year_reg) - cent_x100);
        leap      = is_leap(yr_mod100, s1_cent_reg[1:0]);
        len       = month_len(s1_month_reg, leap);
        bad       = (len == '0) || (s1_day_reg == '0) || (s1_day_reg > SDAY_W'(len));

        job_next           = '0;
        job_next.year      = s1_year_reg;
        job_next.month     = s1_month_reg;
        job_next.day       = DAY_W'(s1_day_reg);
        job_next.rem       = s1_off_reg;
        job_next.yr_mod100 = yr_mod100;
        job_next.cent_mod4 = s1_cent_reg[1:0];
        if (bad)
        begin
            job_next.status = ST_BAD_DATE;
        end
        else if (s1_year_reg > YEAR_MAX)
        begin
            job_next.status = ST_OVERFLOW;
        end
        else
        begin
            job_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= push;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_year_reg  <= start_year;
            s1_month_reg <= start_month;
            s1_day_reg   <= start_day;
            s1_off_reg   <= day_offset[OFFSET_BITS-1:0];
            s1_cent_reg  <= prod[DIV100_SHIFT +: CENT_W];
        end
        if (s1_move)
        begin
            s2_job_reg <= job_next;
        end
    end

    assign job_push = s2_valid_reg && !job_full;
    assign job      = s2_job_reg;

endmodule

>>> src/dad_queue.sv
// Short job queue between the front end and the month stepper.
// Depends on dad_pkg.
module dad_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  dad_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output dad_pkg::job_t rd_data,
    output logic          empty
);
    import dad_pkg::*;

    job_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/dad_back.sv
// Back end of the date adder: steps the date one month per cycle and holds
// the finished word in the output register. Depends on dad_pkg.
module dad_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_empty,
    input  dad_pkg::job_t job,
    output logic          job_pop,
    output logic          empty,
    input  logic          pop,
    output logic [1:0]    status,
    output logic [13:0]   result_year,
    output logic [3:0]    result_month,
    output logic [4:0]    result_day
);
    import dad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    status_t                status_reg, status_next;
    logic [YEAR_W-1:0]      year_reg, year_next;
    logic [MONTH_W-1:0]     month_reg, month_next;
    logic [DAY_W-1:0]       day_reg, day_next;
    logic [OFFSET_BITS-1:0] rem_reg, rem_next;
    logic [MOD100_W-1:0]    mod100_reg, mod100_next;
    logic [1:0]             cent4_reg, cent4_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg;
    logic [YEAR_W-1:0]      out_year_reg;
    logic [MONTH_W-1:0]     out_month_reg;
    logic [DAY_W-1:0]       out_day_reg;

    logic [DAY_W-1:0]       len;
    logic [DAY_W-1:0]       room;
    logic                   fits;
    logic                   out_free;
    logic                   load_out;

    assign len      = month_len(month_reg, is_leap(mod100_reg, cent4_reg));
    assign room     = len - day_reg;
    assign fits     = rem_reg <= OFFSET_BITS'(room);
    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        rem_next    = rem_reg;
        mod100_next = mod100_reg;
        cent4_next  = cent4_reg;
        job_pop     = 1'b0;
        load_out    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop     = 1'b1;
                    status_next = job.status;
                    year_next   = job.year;
                    month_next  = job.month;
                    day_next    = job.day;
                    rem_next    = job.rem;
                    mod100_next = job.yr_mod100;
                    cent4_next  = job.cent_mod4;
                    state_next  = (job.status == ST_OK) ? S_RUN : S_DONE;
                end
            end
            S_RUN:
            begin
                if (fits)
                begin
                    day_next   = day_reg + rem_reg[DAY_W-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next = rem_reg - OFFSET_BITS'(room) - 1'b1;
                    day_next = DAY_W'(1);
                    if (month_reg == MONTH_DEC)
                    begin
                        month_next = MONTH_JAN;
                        if (year_reg == YEAR_MAX)
                        begin
                            status_next = ST_OVERFLOW;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            year_next = year_reg + 1'b1;
                            if (mod100_reg == MOD100_LAST)
                            begin
                                mod100_next = '0;
                                cent4_next  = cent4_reg + 1'b1;
                            end
                            else
                            begin
                                mod100_next = mod100_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !pop) || load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        rem_reg    <= rem_next;
        mod100_reg <= mod100_next;
        cent4_reg  <= cent4_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            if (status_reg == ST_OK)
            begin
                out_year_reg  <= year_reg;
                out_month_reg <= month_reg;
                out_day_reg   <= day_reg;
            end
            else
            begin
                out_year_reg  <= '0;
                out_month_reg <= '0;
                out_day_reg   <= '0;
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign status       = out_status_reg;
    assign result_year  = out_year_reg;
    assign result_month = out_month_reg;
    assign result_day   = out_day_reg;

    a_run_month_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC))
        else $error("month out of range while stepping");

    a_run_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (day_reg >= DAY_W'(1)) && (day_reg <= len))
        else $error("day outside the current month while stepping");

    a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) && !fits |=> rem_reg < $past(rem_reg))
        else $error("remaining offset did not shrink after a month step");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ST_OK) |->
            (out_year_reg == '0) && (out_month_reg == '0) && (out_day_reg == '0))
        else $error("error word carries a nonzero date");

endmodule

>>> src/date_add_days_top.sv
// Top level of the Gregorian date adder: front end, job queue and month stepper.
// Depends on dad_pkg, dad_front, dad_queue and dad_back.
//
// The input channel takes a start date and a day offset: a word is accepted on a
// rising edge with push high and full low. The result channel shows the oldest
// finished word while empty is low; it is taken on a rising edge with pop high.
// Each input word gives exactly one result word with a status: ok, invalid start
// date, or year overflow past 9999; the date fields are zero unless status is ok.
// The front end validates a word in its registers s1 and s2 and passes it into a
// two-entry queue, so it keeps accepting while the stepper is busy.
// The stepper advances one calendar month per cycle: a valid item is loaded in
// S_IDLE, stepped in S_RUN once per month crossed and once more to add the last
// days, then waits in S_DONE until the output register is free and is loaded.
// An invalid or out-of-range word skips the month loop and goes to S_DONE.
// A 16-bit offset spans at most about 2200 months; that loop sets the throughput.
// A word passes s1, s2, the queue and the stepper before empty goes low.
// When pop stays low, the finished word holds, the stepper waits, then the queue
// and front end fill and full rises. Reset clears all valid flags and the
// stepper state; no word is in flight afterward.
module date_add_days_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [13:0] start_year,
    input  logic [3:0]  start_month,
    input  logic [5:0]  start_day,
    input  logic [15:0] day_offset,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [13:0] result_year,
    output logic [3:0]  result_month,
    output logic [4:0]  result_day
);
    import dad_pkg::*;

    logic job_push;
    job_t job_in;
    logic job_full;
    logic job_pop;
    job_t job_out;
    logic job_empty;

    dad_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .start_year  (start_year),
        .start_month (start_month),
        .start_day   (start_day),
        .day_offset  (day_offset),
        .job_push    (job_push),
        .job         (job_in),
        .job_full    (job_full)
    );

    dad_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    dad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_empty    (job_empty),
        .job          (job_out),
        .job_pop      (job_pop),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day)
    );

endmodule
